### design/wrf_pkg.sv
package wrf_pkg;

    localparam int MAX_SAMPLES = 16384;
    localparam int MAX_PAD     = 31;
    localparam int HALF_WINDOW = 3;
    localparam int WIN         = 2 * HALF_WINDOW + 1;
    localparam int LATENCY     = MAX_PAD + HALF_WINDOW;
    // cells hold view positions 1 .. LATENCY+MAX_PAD; view 0 is the incoming item
    localparam int NCELL       = LATENCY + MAX_PAD;
    localparam int POS_W       = $clog2(NCELL + 1);
    localparam int FCNT_W      = $clog2(LATENCY + 1);
    localparam int FIFO_DEPTH  = 2;

    localparam int SAMPLE_W    = 12;
    localparam int IDX_W       = 14;
    localparam int VAL_W       = 17;
    localparam int PED_W       = 16;
    localparam int WTHR_W      = 19;
    localparam int STHR_W      = 12;
    localparam int PAD_W       = 5;
    localparam int CFG_W       = 19;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PEDESTAL         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_PAD          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_PAD         = 3'd4;

    typedef enum logic
    {
        MODE_RUN,
        MODE_FLUSH
    } mode_t;

    typedef struct packed
    {
        logic [PED_W-1:0]  pedestal;
        logic [WTHR_W-1:0] window_threshold;
        logic [STHR_W-1:0] sample_threshold;
        logic [PAD_W-1:0]  pre_pad;
        logic [PAD_W-1:0]  post_pad;
    } cfg_t;

    typedef struct packed
    {
        logic [SAMPLE_W-1:0] sample;
        logic                live;
        logic                roi;
        logic                opener;
    } entry_t;

    typedef struct packed
    {
        logic [POS_W-1:0] cov_lo;
        logic [POS_W-1:0] cov_hi;
        logic [POS_W-1:0] blk_lo;
        logic [POS_W-1:0] start_pos;
    } win_t;

    typedef struct packed
    {
        logic cov;
        logic blk;
        logic opener;
    } hit_t;

    typedef struct packed
    {
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    region_start;
        logic                    last;
    } result_t;

    typedef logic [WIN-1:0][SAMPLE_W-1:0] taps_t;

endpackage

### design/wrf_cell.sv
module wrf_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift,
    input  logic                        clear,
    input  logic                        set_roi,
    input  logic                        set_opener,
    input  wrf_pkg::entry_t             d,
    input  logic [wrf_pkg::POS_W-1:0]   pos,
    input  wrf_pkg::win_t               win,
    output wrf_pkg::entry_t             q,
    output wrf_pkg::hit_t               hit
);
    import wrf_pkg::*;

    logic [SAMPLE_W-1:0] sample_reg;
    logic                live_reg;
    logic                live_next;
    logic                roi_reg;
    logic                roi_next;
    logic                opener_reg;
    logic                opener_next;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            sample_reg <= d.sample;
        end
    end

    always_comb
    begin
        live_next   = live_reg;
        roi_next    = roi_reg;
        opener_next = opener_reg;
        if (clear)
        begin
            live_next   = 1'b0;
            roi_next    = 1'b0;
            opener_next = 1'b0;
        end
        else if (shift)
        begin
            live_next   = d.live;
            roi_next    = d.roi;
            opener_next = d.opener;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg   <= 1'b0;
            roi_reg    <= 1'b0;
            opener_reg <= 1'b0;
        end
        else
        begin
            live_reg   <= live_next;
            roi_reg    <= roi_next;
            opener_reg <= opener_next;
        end
    end

    // a fresh decision shows up in this cell's view before it is stored downstream
    always_comb
    begin
        q.sample = sample_reg;
        q.live   = live_reg;
        q.roi    = roi_reg | set_roi;
        q.opener = opener_reg | set_opener;
        hit.cov    = q.roi && (pos >= win.cov_lo) && (pos <= win.cov_hi);
        hit.blk    = q.roi && (pos >= win.blk_lo) && (pos <= win.cov_hi);
        hit.opener = q.opener && (pos == win.start_pos);
    end

endmodule

### design/wrf_decider.sv
module wrf_decider (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tick,
    input  logic           clear,
    input  logic           en,
    input  wrf_pkg::taps_t taps,
    input  wrf_pkg::cfg_t  cfg,
    output logic           set_roi,
    output logic           set_opener
);
    import wrf_pkg::*;

    localparam int SSUM_W = SAMPLE_W + $clog2(WIN);
    localparam int SUM_W  = SSUM_W + 6;

    logic                    roi_open_reg;
    logic                    roi_open_next;
    logic [SSUM_W-1:0]       ssum;
    logic [SUM_W-1:0]        ped7;
    logic signed [SUM_W-1:0] wsum;
    logic [SUM_W-1:0]        wabs;
    logic signed [VAL_W-1:0] dev;
    logic [VAL_W-1:0]        dabs;
    logic                    open_hit;
    logic                    close_hit;

    // window sum of (16*adc - pedestal) is 16*sum(adc) - 7*pedestal
    always_comb
    begin
        ssum = '0;
        for (int i = 0; i < WIN; i++)
        begin
            ssum = ssum + SSUM_W'(taps[i]);
        end
        ped7 = (SUM_W'(cfg.pedestal) << 3) - SUM_W'(cfg.pedestal);
        wsum = signed'((SUM_W'(ssum) << 4) - ped7);
        wabs = wsum[SUM_W-1] ? SUM_W'(-wsum) : SUM_W'(wsum);
        open_hit = wabs > SUM_W'(cfg.window_threshold);

        dev  = signed'({1'b0, taps[HALF_WINDOW], 4'b0000}) - signed'({1'b0, cfg.pedestal});
        dabs = dev[VAL_W-1] ? VAL_W'(-dev) : VAL_W'(dev);
        close_hit = dabs < {1'b0, cfg.sample_threshold, 4'b0000};

        set_roi    = en && (roi_open_reg || open_hit);
        set_opener = en && !roi_open_reg && open_hit;

        roi_open_next = roi_open_reg;
        if (clear)
        begin
            roi_open_next = 1'b0;
        end
        else if (tick && en)
        begin
            roi_open_next = roi_open_reg ? !close_hit : open_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roi_open_reg <= 1'b0;
        end
        else
        begin
            roi_open_reg <= roi_open_next;
        end
    end

endmodule

### design/wrf_result_fifo.sv
module wrf_result_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wrf_pkg::result_t din,
    input  logic             stall,
    output logic             valid,
    output wrf_pkg::result_t dout,
    output logic             full
);
    import wrf_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    result_t          mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign valid = count_reg != '0;
    assign full  = count_reg == CNT_W'(FIFO_DEPTH);
    assign dout  = mem[rd_ptr_reg];
    assign pop   = valid && !stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/waveform_roi_finder_core.sv
// Throughput: one sample item per cycle, set by the shift of the cell chain, while
// sample_stall is low. Sample j is pushed to the output queue in the cycle that
// accepts sample j+34 and is registered there before it shows on the result port.
// A last sample starts a flush (held while the output queue is full) that emits the
// remaining samples and then clears the chain; sample input is stalled meanwhile.
// Reset (rst_n, asynchronous, active low) clears the chain flags, ROI state and config.
module waveform_roi_finder_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic [wrf_pkg::SAMPLE_W-1:0]         adc_sample,
    input  logic                                 last_sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [wrf_pkg::IDX_W-1:0]            sample_index,
    output logic signed [wrf_pkg::VAL_W-1:0]     inverted_value,
    output logic                                 region_start,
    output logic                                 last_result,
    input  logic                                 cfg_write,
    input  logic [wrf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wrf_pkg::CFG_W-1:0]            cfg_data
);
    import wrf_pkg::*;

    cfg_t                cfg_reg;
    mode_t               state_reg;
    mode_t               state_next;
    logic [FCNT_W-1:0]   flush_cnt_reg;
    logic [FCNT_W-1:0]   flush_cnt_next;
    logic [IDX_W-1:0]    count_reg;
    logic [IDX_W-1:0]    count_next;
    logic [SAMPLE_W-1:0] first_sample_reg;
    logic [SAMPLE_W-1:0] first_sample_next;
    result_t             pend_reg;
    result_t             pend_next;
    logic                pend_valid_reg;
    logic                pend_valid_next;

    logic                fifo_full;
    logic                accept;
    logic                last_in;
    logic                shift;
    logic                drain;
    logic                group;
    logic                push;
    result_t             push_data;
    result_t             head_item;

    entry_t              head;
    entry_t              chain_in [NCELL];
    entry_t              view [NCELL];
    hit_t                hits [NCELL];
    logic [NCELL-1:0]    cov_vec;
    logic [NCELL-1:0]    blk_vec;
    logic [NCELL-1:0]    opener_vec;
    logic [NCELL-1:0]    set_roi_vec;
    logic [NCELL-1:0]    set_opener_vec;
    win_t                win;
    taps_t               taps;
    logic                dec_en;
    logic                set_roi;
    logic                set_opener;
    logic                emit_valid;
    result_t             emit_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PEDESTAL:         cfg_reg.pedestal         <= cfg_data[PED_W-1:0];
                CFG_WINDOW_THRESHOLD: cfg_reg.window_threshold <= cfg_data[WTHR_W-1:0];
                CFG_SAMPLE_THRESHOLD: cfg_reg.sample_threshold <= cfg_data[STHR_W-1:0];
                CFG_PRE_PAD:          cfg_reg.pre_pad          <= cfg_data[PAD_W-1:0];
                CFG_POST_PAD:         cfg_reg.post_pad         <= cfg_data[PAD_W-1:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign sample_stall = (state_reg == MODE_FLUSH) || fifo_full;
    assign accept       = sample_valid && !sample_stall;
    assign last_in      = last_sample || (count_reg == IDX_W'(MAX_SAMPLES - 1));

    // during the flush, replicate the final sample so the window clamps at the end
    always_comb
    begin
        head.sample = (state_reg == MODE_FLUSH) ? view[0].sample : adc_sample;
        head.live   = state_reg == MODE_RUN;
        head.roi    = 1'b0;
        head.opener = 1'b0;
    end

    always_comb
    begin
        win.cov_lo    = POS_W'(LATENCY) - POS_W'(cfg_reg.pre_pad);
        win.cov_hi    = POS_W'(LATENCY) + POS_W'(cfg_reg.post_pad);
        win.blk_lo    = win.cov_lo + 1'b1;
        win.start_pos = win.cov_lo;
    end

    assign chain_in[0]    = head;
    assign set_roi_vec    = NCELL'(set_roi) << (HALF_WINDOW - 1);
    assign set_opener_vec = NCELL'(set_opener) << (HALF_WINDOW - 1);

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            if (gi > 0)
            begin : g_link
                assign chain_in[gi] = view[gi-1];
            end
            wrf_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (shift),
                .clear      (drain),
                .set_roi    (set_roi_vec[gi]),
                .set_opener (set_opener_vec[gi]),
                .d          (chain_in[gi]),
                .pos        (POS_W'(gi + 1)),
                .win        (win),
                .q          (view[gi]),
                .hit        (hits[gi])
            );
            assign cov_vec[gi]    = hits[gi].cov;
            assign blk_vec[gi]    = hits[gi].blk;
            assign opener_vec[gi] = hits[gi].opener;
        end
    endgenerate

    // bins before the waveform start take the value of bin zero
    always_comb
    begin
        taps[0] = head.sample;
        for (int i = 1; i < WIN; i++)
        begin
            if (i <= HALF_WINDOW)
            begin
                taps[i] = view[i-1].sample;
            end
            else
            begin
                taps[i] = view[i-1].live ? view[i-1].sample : first_sample_reg;
            end
        end
    end

    assign dec_en = view[HALF_WINDOW-1].live && ((count_reg - IDX_W'(HALF_WINDOW)) != '0);

    wrf_decider u_decider (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (shift),
        .clear      (drain),
        .en         (dec_en),
        .taps       (taps),
        .cfg        (cfg_reg),
        .set_roi    (set_roi),
        .set_opener (set_opener)
    );

    always_comb
    begin
        emit_valid          = view[LATENCY-1].live && (|cov_vec);
        emit_item.index     = count_reg - IDX_W'(LATENCY);
        emit_item.value     = signed'({1'b0, cfg_reg.pedestal})
                              - signed'({1'b0, view[LATENCY-1].sample, 4'b0000});
        emit_item.region_start = (emit_item.index == '0) || ((|opener_vec) && !(|blk_vec));
        emit_item.last      = 1'b1;
    end

    always_comb
    begin
        state_next        = state_reg;
        flush_cnt_next    = flush_cnt_reg;
        count_next        = count_reg;
        first_sample_next = first_sample_reg;
        pend_next         = pend_reg;
        pend_valid_next   = pend_valid_reg;
        shift             = 1'b0;
        drain             = 1'b0;
        group             = 1'b0;
        push              = 1'b0;
        push_data         = emit_item;

        case (state_reg)
            MODE_RUN:
            begin
                if (accept)
                begin
                    shift      = 1'b1;
                    group      = last_in;
                    count_next = count_reg + 1'b1;
                    if (count_reg == '0)
                    begin
                        first_sample_next = adc_sample;
                    end
                    if (last_in)
                    begin
                        state_next     = MODE_FLUSH;
                        flush_cnt_next = FCNT_W'(LATENCY);
                    end
                end
            end
            MODE_FLUSH:
            begin
                if (!fifo_full)
                begin
                    if (flush_cnt_reg != '0)
                    begin
                        shift          = 1'b1;
                        group          = 1'b1;
                        count_next     = count_reg + 1'b1;
                        flush_cnt_next = flush_cnt_reg - 1'b1;
                    end
                    else
                    begin
                        drain      = 1'b1;
                        count_next = '0;
                        state_next = MODE_RUN;
                    end
                end
            end
            default:
            begin
                state_next = MODE_RUN;
            end
        endcase

        // inside the final group, hold each result until the next one shows it is not last
        if (shift && !group)
        begin
            push = emit_valid;
        end
        else if (shift && group && emit_valid)
        begin
            push           = pend_valid_reg;
            push_data      = pend_reg;
            push_data.last = 1'b0;
            pend_next      = emit_item;
            pend_valid_next = 1'b1;
        end
        else if (drain)
        begin
            push           = pend_valid_reg;
            push_data      = pend_reg;
            push_data.last = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg         <= pend_next;
        first_sample_reg <= first_sample_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= MODE_RUN;
            flush_cnt_reg  <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            flush_cnt_reg  <= flush_cnt_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    wrf_result_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_data),
        .stall (result_stall),
        .valid (result_valid),
        .dout  (head_item),
        .full  (fifo_full)
    );

    assign sample_index   = head_item.index;
    assign inverted_value = head_item.value;
    assign region_start   = head_item.region_start;
    assign last_result    = head_item.last;

endmodule

### tb/sv/waveform_roi_finder_core_tb.sv
module waveform_roi_finder_core_tb;
    import wrf_pkg::*;

    localparam int HIST_DEPTH  = 128;
    localparam int HIST_MASK   = HIST_DEPTH - 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = LATENCY + 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                       clk;
    logic                       rst_n;
    logic                       sample_valid;
    logic                       sample_stall;
    logic [SAMPLE_W-1:0]        adc_sample;
    logic                       last_sample;
    logic                       result_valid;
    logic                       result_stall;
    logic [IDX_W-1:0]           sample_index;
    logic signed [VAL_W-1:0]    inverted_value;
    logic                       region_start;
    logic                       last_result;
    logic                       cfg_write;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;

    // predictor state
    logic [SAMPLE_W-1:0] hist [HIST_DEPTH];
    bit                  opener_mark [HIST_DEPTH];
    bit                  roi_mark [HIST_DEPTH];
    int                  wave_pos;
    bit                  roi_now;
    cfg_t                regs;
    result_t             emitted_due [$];

    int mismatch_count;
    int quiet_cycles;
    int hold_left;
    bit gaps_on;

    waveform_roi_finder_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .adc_sample     (adc_sample),
        .last_sample    (last_sample),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .sample_index   (sample_index),
        .inverted_value (inverted_value),
        .region_start   (region_start),
        .last_result    (last_result),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_waveform();
        int i;
        for (i = 0; i < HIST_DEPTH; i++)
        begin
            hist[i] = '0;
            opener_mark[i] = 1'b0;
            roi_mark[i] = 1'b0;
        end
        wave_pos = 0;
        roi_now = 1'b0;
    endfunction

    function automatic int deviation_at(int b);
        return int'(hist[b & HIST_MASK]) * 16 - int'(regs.pedestal);
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit any_roi(int lo, int hi, int n);
        int b;
        if (lo < 0)
            lo = 0;
        if (hi > n)
            hi = n;
        for (b = lo; b <= hi; b++)
            if (roi_mark[b & HIST_MASK])
                return 1'b1;
        return 1'b0;
    endfunction

    // open on the clamped 7-bin window sum, close on the first quiet bin
    function automatic void judge_bin(int k, int n);
        int     b;
        int     d;
        int     slot;
        longint sum;
        slot = k & HIST_MASK;
        if (!roi_now)
        begin
            sum = 0;
            for (d = -HALF_WINDOW; d <= HALF_WINDOW; d++)
            begin
                b = k + d;
                if (b < 0)
                    b = 0;
                if (b > n)
                    b = n;
                sum += deviation_at(b);
            end
            if (magnitude(sum) > longint'(regs.window_threshold))
            begin
                roi_now = 1'b1;
                opener_mark[slot] = 1'b1;
                roi_mark[slot] = 1'b1;
            end
        end
        else
        begin
            roi_mark[slot] = 1'b1;
            if (magnitude(deviation_at(k)) < longint'(regs.sample_threshold) * 16)
                roi_now = 1'b0;
        end
    endfunction

    function automatic int emit_if_covered(int j, int n);
        result_t r;
        int      pre;
        int      post;
        pre = int'(regs.pre_pad);
        post = int'(regs.post_pad);
        if (!any_roi(j - post, j + pre, n))
            return 0;
        r.index = IDX_W'(j);
        r.value = VAL_W'(-deviation_at(j));
        if (j == 0)
            r.region_start = 1'b1;
        else
            r.region_start = (j + pre <= n) && opener_mark[(j + pre) & HIST_MASK] &&
                             !any_roi(j - post, j + pre - 1, n);
        r.last = 1'b0;
        emitted_due = {emitted_due, r};
        return 1;
    endfunction

    function automatic void find_roi_emits(logic [SAMPLE_W-1:0] adc, logic ends);
        int n;
        int k;
        int j;
        int slot;
        int pushed;
        bit ending;
        n = wave_pos;
        slot = n & HIST_MASK;
        ending = ends || (n >= MAX_SAMPLES - 1);
        hist[slot] = adc;
        opener_mark[slot] = 1'b0;
        roi_mark[slot] = 1'b0;
        pushed = 0;
        if (ending)
        begin
            for (k = (n - HALF_WINDOW > 1) ? n - HALF_WINDOW : 1; k <= n; k++)
                judge_bin(k, n);
            for (j = (n - LATENCY > 0) ? n - LATENCY : 0; j <= n; j++)
                pushed += emit_if_covered(j, n);
        end
        else
        begin
            if (n - HALF_WINDOW >= 1)
                judge_bin(n - HALF_WINDOW, n);
            if (n >= LATENCY)
                pushed += emit_if_covered(n - LATENCY, n);
        end
        if (pushed > 0)
            emitted_due[emitted_due.size() - 1].last = 1'b1;
        if (ending)
            clear_waveform();
        else
            wave_pos = n + 1;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("error: %s", what);
    endtask

    task automatic check_result();
        result_t want;
        if (emitted_due.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing expected, index %0d", sample_index));
            return;
        end
        want = emitted_due.pop_front();
        if (sample_index !== want.index)
            report_mismatch($sformatf("sample_index %0d, expected %0d",
                                      sample_index, want.index));
        if (inverted_value !== want.value)
            report_mismatch($sformatf("index %0d: inverted_value %0d, expected %0d",
                                      want.index, inverted_value, want.value));
        if (region_start !== want.region_start)
            report_mismatch($sformatf("index %0d: region_start %b, expected %b",
                                      want.index, region_start, want.region_start));
        if (last_result !== want.last)
            report_mismatch($sformatf("index %0d: last_result %b, expected %b",
                                      want.index, last_result, want.last));
    endtask

    // predict on accepted samples first; a result never depends on the item of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                find_roi_emits(adc_sample, last_sample);
            if (result_valid && !result_stall)
                check_result();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("waveform_roi_finder_core: mismatch");
                $finish;
            end
        end
    end

    // result side: random stall after each item, plus a long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                stall_left = gaps_on ? $urandom_range(0, 13) : 0;
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    task automatic send_sample(logic [SAMPLE_W-1:0] adc, logic ends);
        int gap;
        gap = gaps_on ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        adc_sample <= adc;
        last_sample <= ends;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    task automatic send_waveform(input int wave[$]);
        int i;
        for (i = 0; i < wave.size(); i++)
            send_sample(SAMPLE_W'(wave[i]), i == wave.size() - 1);
    endtask

    function automatic logic [SAMPLE_W-1:0] clamp_adc(int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return '1;
        return SAMPLE_W'(v);
    endfunction

    // wait for every expected result, then let a pending flush run out
    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (emitted_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value, int width);
        logic [CFG_W-1:0] data;
        data = CFG_W'(value);
        // garbage above the register width must be dropped
        if ($urandom_range(0, 1))
            data |= CFG_W'($urandom) & ~CFG_W'((1 << width) - 1);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_PEDESTAL:         regs.pedestal = data[PED_W-1:0];
            CFG_WINDOW_THRESHOLD: regs.window_threshold = data[WTHR_W-1:0];
            CFG_SAMPLE_THRESHOLD: regs.sample_threshold = data[STHR_W-1:0];
            CFG_PRE_PAD:          regs.pre_pad = data[PAD_W-1:0];
            CFG_POST_PAD:         regs.post_pad = data[PAD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(int ped, int wthr, int sthr, int pre, int post);
        drain();
        write_reg(CFG_PEDESTAL, ped, PED_W);
        write_reg(CFG_WINDOW_THRESHOLD, wthr, WTHR_W);
        write_reg(CFG_SAMPLE_THRESHOLD, sthr, STHR_W);
        write_reg(CFG_PRE_PAD, pre, PAD_W);
        write_reg(CFG_POST_PAD, post, PAD_W);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_waveform(int len, int pause_at);
        int kind;
        int base;
        int pulse_left;
        int amp;
        int v;
        int i;
        kind = $urandom_range(0, 9);
        base = int'(regs.pedestal) >> 4;
        pulse_left = 0;
        amp = 0;
        for (i = 0; i < len; i++)
        begin
            if (i == pause_at)
            begin
                sample_valid <= 1'b0;
                @(posedge clk);
                while (emitted_due.size() != 0)
                    @(posedge clk);
            end
            if (kind == 0)
                v = $urandom_range(0, 4095);
            else
            begin
                if (pulse_left == 0 && $urandom_range(0, 9) == 0)
                begin
                    pulse_left = $urandom_range(1, 8);
                    amp = $urandom_range(10, 1500);
                    if ($urandom_range(0, 1))
                        amp = -amp;
                end
                v = base + int'($urandom_range(0, 6)) - 3;
                if (pulse_left > 0)
                begin
                    v += amp;
                    pulse_left--;
                end
            end
            send_sample(clamp_adc(v), i == len - 1);
        end
    endtask

    task automatic test_reset_config();
        int wave[$];
        wave = '{0, 4095, 0, 4095, 0};
        send_waveform(wave);
        // a lone sample opens nothing
        wave = '{4095};
        send_waveform(wave);
    endtask

    task automatic test_bin_zero_padding();
        int wave[$];
        configure(16 * 1000, 16 * 300, 20, 31, 31);
        wave = '{1000, 1000, 1000, 1000, 1600, 1000, 1000, 1000};
        send_waveform(wave);
    endtask

    task automatic test_value_extremes();
        int wave[$];
        configure(16'hFFFF, 0, 0, 0, 0);
        wave = '{0, 4095, 0};
        send_waveform(wave);
        configure(0, 0, 0, 0, 0);
        wave = '{4095, 4095};
        send_waveform(wave);
    endtask

    task automatic test_adjacent_regions();
        int wave[$];
        drain();
        write_reg(CFG_SPARE, $urandom, CFG_W);
        configure(16 * 1000, 16 * 100, 50, 0, 0);
        wave = '{1000, 1000, 1000, 1500, 1000, 1000, 1000, 1000};
        send_waveform(wave);
    endtask

    // hold results off so the block fills and pushes back on its input
    task automatic test_output_backpressure();
        int i;
        configure(16 * 2000, 0, 0, 31, 31);
        gaps_on = 1'b0;
        hold_left = 200;
        for (i = 0; i < 50; i++)
            send_sample(clamp_adc(2000 + int'($urandom_range(0, 10)) - 5), i == 49);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_waveforms();
        int phase;
        int used;
        int len;
        int r;
        int count;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1: configure(0, 0, 4095, 31, 0);
                2: configure(16'hFFFF, 19'h7FFFF, 0, 0, 31);
                default: configure($urandom_range(200, 3900) * 16 + $urandom_range(0, 15),
                                   $urandom_range(20, 1500) * 16, $urandom_range(0, 40),
                                   $urandom_range(0, 31), $urandom_range(0, 31));
            endcase
            used = 0;
            count = 0;
            while (used < 12)
            begin
                r = $urandom_range(0, 9);
                if (r < 2)
                    len = $urandom_range(1, 4);
                else if (r < 8)
                    len = $urandom_range(5, 30);
                else
                    len = $urandom_range(40, 75);
                gaps_on = ($urandom_range(0, 3) != 0);
                send_random_waveform(len, (phase == 0 && count == 0) ? len / 2 : -1);
                used += len;
                count++;
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        mismatch_count = 0;
        quiet_cycles = 0;
        hold_left = 0;
        gaps_on = 1'b1;
        regs = '0;
        clear_waveform();
        rst_n <= 1'b0;
        sample_valid <= 1'b0;
        adc_sample <= '0;
        last_sample <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_bin_zero_padding();
        test_value_extremes();
        test_adjacent_regions();
        test_output_backpressure();
        test_random_waveforms();
        drain();
        if (mismatch_count == 0)
            $display("waveform_roi_finder_core: match");
        else
            $display("waveform_roi_finder_core: mismatch");
        $finish;
    end

endmodule
